[rtl/ordq_pkg.sv]
package ordq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam logic [31:0] TIME_INF = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_APPEND     = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_REPOSITION = 3'd2,
    CMD_SORT       = 3'd3,
    CMD_READ       = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LOAD_TIME,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic ge;
    logic le;
    logic gt_right;
  } cell_flags_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_FIND,
    S_TAKE,
    S_CMP,
    S_PLACE,
    S_INSERT,
    S_SORT,
    S_FINISH
  } state_t;

endpackage

[rtl/ordq_cell.sv]
module ordq_cell (
  input  logic                 clk,
  input  ordq_pkg::cell_ctl_t  ctl,
  input  logic [15:0]          key_id,
  input  logic [31:0]          key_time,
  input  logic [15:0]          left_id,
  input  logic [31:0]          left_time,
  input  logic [15:0]          right_id,
  input  logic [31:0]          right_time,
  output logic [15:0]          cell_id,
  output logic [31:0]          cell_time,
  output ordq_pkg::cell_flags_t flags
);

  logic [15:0] id_r;
  logic [15:0] id_nxt;
  logic [31:0] time_r;
  logic [31:0] time_nxt;

  always_comb begin
    id_nxt   = id_r;
    time_nxt = time_r;
    case (ctl.op)
      ordq_pkg::CELL_LOAD: begin
        id_nxt   = key_id;
        time_nxt = key_time;
      end
      ordq_pkg::CELL_LOAD_TIME: begin
        time_nxt = key_time;
      end
      ordq_pkg::CELL_FROM_LEFT: begin
        id_nxt   = left_id;
        time_nxt = left_time;
      end
      ordq_pkg::CELL_FROM_RIGHT: begin
        id_nxt   = right_id;
        time_nxt = right_time;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    time_r <= time_nxt;
  end

  assign cell_id        = id_r;
  assign cell_time      = time_r;
  assign flags.match    = (id_r == key_id);
  assign flags.ge       = (time_r >= key_time);
  assign flags.le       = (time_r <= key_time);
  assign flags.gt_right = (time_r > right_time);

endmodule

[rtl/ordered_event_time_queue.sv]
// Ordered event-time queue built as a row of cells, one (id, time) entry per
// cell, each cell able to take its left or right neighbor's entry. One command
// is accepted at a time and gives one result beat. Append, clear, read, unused
// codes and commands refused on an empty list go from execute straight to the
// finish step; an id that is not present ends after the search; remove, and
// reposition of a lone entry, end after the take-out; any other reposition
// runs search, take out, compare against the new time, choose the slot and
// insert; sort runs odd-even transposition passes over the row. The last step
// holds while the output register is full and stalled, and the block returns
// to idle before the next command is taken. A new command is taken while the
// previous result still waits on the output register.
module ordered_event_time_queue #(
  parameter int unsigned CAPACITY = ordq_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [15:0] in_entry_id,
  input  logic [31:0] in_event_time,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_count,
  output logic [15:0] out_read_id,
  output logic [31:0] out_read_time
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;

  ordq_pkg::state_t state_r, state_nxt;

  logic [2:0]     cmd_r;
  logic [15:0]    id_r;
  logic [31:0]    time_r;
  logic [5:0]     pos_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic [IW-1:0]  p_r, p_nxt;
  logic [CW-1:0]  q_r, q_nxt;
  logic [CW-1:0]  sort_cnt_r, sort_cnt_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [CAPACITY-1:0] ge_r, ge_nxt;
  logic [CAPACITY-1:0] le_r, le_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [15:0]    res_id_r, res_id_nxt;
  logic [31:0]    res_time_r, res_time_nxt;
  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [CW-1:0]  out_count_r;
  logic [15:0]    out_id_r;
  logic [31:0]    out_time_r;

  ordq_pkg::cell_ctl_t   cell_ctl   [CAPACITY];
  ordq_pkg::cell_flags_t cell_flags [CAPACITY];
  logic [15:0] cell_id   [CAPACITY];
  logic [31:0] cell_time [CAPACITY];

  logic          accept;
  logic          out_free;
  logic [PW-1:0] pos_ext;
  logic [IW-1:0] p_first;
  logic [IW-1:0] last_idx;
  logic [CW-1:0] up_q;
  logic          up_hit;
  logic [CW-1:0] dn_q;
  logic          dn_hit;
  logic [CAPACITY-1:0] valid_vec;
  logic [15:0]   rd_id;
  logic [31:0]   rd_time;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [15:0] l_id, r_id;
      logic [31:0] l_time, r_time;
      if (g == 0) begin : g_first
        assign l_id   = '0;
        assign l_time = '0;
      end else begin : g_mid_l
        assign l_id   = cell_id[g-1];
        assign l_time = cell_time[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign r_id   = '0;
        assign r_time = '0;
      end else begin : g_mid_r
        assign r_id   = cell_id[g+1];
        assign r_time = cell_time[g+1];
      end
      ordq_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl[g]),
        .key_id     (id_r),
        .key_time   (time_r),
        .left_id    (l_id),
        .left_time  (l_time),
        .right_id   (r_id),
        .right_time (r_time),
        .cell_id    (cell_id[g]),
        .cell_time  (cell_time[g]),
        .flags      (cell_flags[g])
      );
    end
  endgenerate

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ordq_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign pos_ext  = PW'(pos_r);
  assign last_idx = IW'(count_r - CW'(1));

  // Per-cell occupancy, id match and read mux over the row.
  always_comb begin
    rd_id   = '0;
    rd_time = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = (CW'(i) < count_r);
      match_nxt[i] = cell_flags[i].match && valid_vec[i];
      ge_nxt[i]    = cell_flags[i].ge;
      le_nxt[i]    = cell_flags[i].le;
      if (PW'(i) == pos_ext) begin
        rd_id   = rd_id | cell_id[i];
        rd_time = rd_time | cell_time[i];
      end
    end
  end

  // Priority encoders for the first match and the reposition targets.
  always_comb begin
    p_first = '0;
    up_hit  = 1'b0;
    up_q    = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        p_first = IW'(i);
      end
      if (ge_r[i] && (CW'(i) >= CW'(p_r)) && (CW'(i) + CW'(1) < count_r)) begin
        up_hit = 1'b1;
        up_q   = CW'(i);
      end
    end
    dn_hit = 1'b0;
    dn_q   = CW'(1);
    for (int i = 1; i < CAPACITY; i++) begin
      if (le_r[i] && (CW'(i) < CW'(p_r))) begin
        dn_hit = 1'b1;
        dn_q   = CW'(i) + CW'(1);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    q_nxt          = q_r;
    sort_cnt_nxt   = sort_cnt_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_time_nxt   = res_time_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].op = ordq_pkg::CELL_HOLD;
    end

    case (state_r)
      ordq_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = ordq_pkg::S_EXEC;
        end
      end

      ordq_pkg::S_EXEC: begin
        res_status_nxt = ordq_pkg::ST_OK;
        res_id_nxt     = '0;
        res_time_nxt   = '0;
        state_nxt      = ordq_pkg::S_FINISH;
        case (cmd_r)
          ordq_pkg::CMD_APPEND: begin
            if (count_r == CW'(CAPACITY)) begin
              res_status_nxt = ordq_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
              for (int i = 0; i < CAPACITY; i++) begin
                if (CW'(i) == count_r) begin
                  cell_ctl[i].op = ordq_pkg::CELL_LOAD;
                end
              end
            end
          end
          ordq_pkg::CMD_REMOVE, ordq_pkg::CMD_REPOSITION: begin
            if (count_r == '0) begin
              res_status_nxt = ordq_pkg::ST_EMPTY;
            end else begin
              state_nxt = ordq_pkg::S_FIND;
            end
          end
          ordq_pkg::CMD_SORT: begin
            if (count_r == '0) begin
              res_status_nxt = ordq_pkg::ST_EMPTY;
            end else begin
              sort_cnt_nxt = '0;
              state_nxt    = ordq_pkg::S_SORT;
            end
          end
          ordq_pkg::CMD_READ: begin
            if (count_r == '0) begin
              res_status_nxt = ordq_pkg::ST_EMPTY;
            end else if (pos_ext >= PW'(count_r)) begin
              res_status_nxt = ordq_pkg::ST_NOTFOUND;
            end else begin
              res_id_nxt   = rd_id;
              res_time_nxt = rd_time;
            end
          end
          ordq_pkg::CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      ordq_pkg::S_FIND: begin
        if (match_r == '0) begin
          res_status_nxt = ordq_pkg::ST_NOTFOUND;
          state_nxt      = ordq_pkg::S_FINISH;
        end else begin
          p_nxt     = p_first;
          state_nxt = ordq_pkg::S_TAKE;
        end
      end

      ordq_pkg::S_TAKE: begin
        if (cmd_r == ordq_pkg::CMD_REMOVE || count_r != CW'(1)) begin
          count_nxt = count_r - CW'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if ((CW'(i) >= CW'(p_r)) && (CW'(i) + CW'(1) < count_r)) begin
              cell_ctl[i].op = ordq_pkg::CELL_FROM_RIGHT;
            end
          end
          state_nxt = (cmd_r == ordq_pkg::CMD_REMOVE) ? ordq_pkg::S_FINISH
                                                       : ordq_pkg::S_CMP;
        end else begin
          // A lone entry only takes its new time.
          cell_ctl[0].op = ordq_pkg::CELL_LOAD_TIME;
          state_nxt      = ordq_pkg::S_FINISH;
        end
      end

      ordq_pkg::S_CMP: begin
        state_nxt = ordq_pkg::S_PLACE;
      end

      ordq_pkg::S_PLACE: begin
        if (time_r == ordq_pkg::TIME_INF || le_r[last_idx]) begin
          q_nxt = count_r;
        end else if (ge_r[0]) begin
          q_nxt = '0;
        end else if ((CW'(p_r) < count_r) && !ge_r[p_r]) begin
          q_nxt = up_hit ? up_q : CW'(last_idx);
        end else if (p_r != '0) begin
          q_nxt = dn_hit ? dn_q : CW'(1);
        end else begin
          q_nxt = '0;
        end
        state_nxt = ordq_pkg::S_INSERT;
      end

      ordq_pkg::S_INSERT: begin
        count_nxt = count_r + CW'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (CW'(i) == q_r) begin
            cell_ctl[i].op = ordq_pkg::CELL_LOAD;
          end else if ((CW'(i) > q_r) && (CW'(i) <= count_r)) begin
            cell_ctl[i].op = ordq_pkg::CELL_FROM_LEFT;
          end
        end
        state_nxt = ordq_pkg::S_FINISH;
      end

      ordq_pkg::S_SORT: begin
        // Pairs start on even cells in even passes and odd cells in odd
        // passes; only a strictly later left entry swaps, which keeps ties
        // in their order.
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if ((i % 2) == int'(sort_cnt_r[0]) && (CW'(i) + CW'(1) < count_r) &&
              cell_flags[i].gt_right) begin
            cell_ctl[i].op   = ordq_pkg::CELL_FROM_RIGHT;
            cell_ctl[i+1].op = ordq_pkg::CELL_FROM_LEFT;
          end
        end
        sort_cnt_nxt = sort_cnt_r + CW'(1);
        if (sort_cnt_r == CW'(CAPACITY - 1)) begin
          state_nxt = ordq_pkg::S_FINISH;
        end
      end

      ordq_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt = ordq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ordq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ordq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == ordq_pkg::S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      id_r   <= in_entry_id;
      time_r <= in_event_time;
      pos_r  <= in_position;
    end
    if (state_r == ordq_pkg::S_EXEC) begin
      match_r <= match_nxt;
    end
    if (state_r == ordq_pkg::S_CMP) begin
      ge_r <= ge_nxt;
      le_r <= le_nxt;
    end
    p_r          <= p_nxt;
    q_r          <= q_nxt;
    sort_cnt_r   <= sort_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_time_r   <= res_time_nxt;
    if (state_r == ordq_pkg::S_FINISH && out_free) begin
      out_status_r <= res_status_r;
      out_count_r  <= count_r;
      out_id_r     <= res_id_r;
      out_time_r   <= res_time_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = 7'(out_count_r);
  assign out_read_id     = out_id_r;
  assign out_read_time   = out_time_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ordq_pkg::S_EXEC)
    else $error("accepted command did not start execution");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ordq_pkg::S_EXEC && cmd_r == ordq_pkg::CMD_APPEND &&
     count_r < CW'(CAPACITY)) |=> count_r == $past(count_r) + CW'(1))
    else $error("append did not grow the list");

  a_sort_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ordq_pkg::S_SORT |=> $stable(count_r))
    else $error("sort changed the entry count");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ordq_pkg::ST_OK) |->
      (out_id_r == '0 && out_time_r == '0))
    else $error("failed command returned read data");

endmodule

[tb/tb_ordered_event_time_queue.sv]
`timescale 1ns / 1ps

module tb_ordered_event_time_queue;

  localparam int CAPACITY = ordq_pkg::CAPACITY_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = CAPACITY + 20;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int SEND_IDLE_PCT[4] = '{0, 61, 0, 9};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 61, 9};

  // Codes the block has no operation for.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] id;
    logic [31:0] t;
    logic [5:0]  pos;
  } order_cmd_t;

  typedef struct packed {
    ordq_pkg::status_t status;
    logic [6:0]        count;
    logic [15:0]       rid;
    logic [31:0]       rtime;
  } order_result_t;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [15:0]   id;
    logic [31:0]   t;
    logic [5:0]    pos;
    logic          typed;
    order_result_t want;
  } dir_row_t;

  localparam order_result_t NO_WANT = '{ordq_pkg::ST_OK, 7'd0, 16'h0, 32'h0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = ordq_pkg::CMD_APPEND;
  logic [15:0] in_entry_id = 16'h0;
  logic [31:0] in_event_time = 32'h0;
  logic [5:0]  in_position = 6'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [6:0]  out_entry_count;
  logic [15:0] out_read_id;
  logic [31:0] out_read_time;

  // Typed expectation that rides along with the beat being offered.
  logic          cur_typed = 1'b0;
  order_result_t cur_want = NO_WANT;

  // Scheduler shadow: entries in list order and the current count.
  logic [15:0] sched_ids [CAPACITY];
  logic [31:0] sched_times [CAPACITY];
  int          sched_len = 0;
  logic        growing = 1'b1;

  order_result_t sched_results_due[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int cmds_seen = 0;
  int results_seen = 0;
  int mismatches = 0;
  int full_hits = 0;
  int peak_len = 0;

  dir_row_t dir_table [26];

  ordered_event_time_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_entry_id     (in_entry_id),
    .in_event_time   (in_event_time),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_read_id     (out_read_id),
    .out_read_time   (out_read_time)
  );

  always #1 clk = ~clk;

  function automatic void sched_take_out(int p);
    int i;
    for (i = p; i + 1 < sched_len; i++) begin
      sched_ids[i] = sched_ids[i + 1];
      sched_times[i] = sched_times[i + 1];
    end
    sched_len--;
  endfunction

  function automatic void sched_put_in(int q, logic [15:0] id, logic [31:0] t);
    int i;
    for (i = sched_len; i > q; i--) begin
      sched_ids[i] = sched_ids[i - 1];
      sched_times[i] = sched_times[i - 1];
    end
    sched_ids[q] = id;
    sched_times[q] = t;
    sched_len++;
  endfunction

  function automatic order_result_t sched_apply(logic [2:0] cmd, logic [15:0] id,
                                                logic [31:0] t, logic [5:0] pos);
    order_result_t r;
    int            p;
    int            m;
    int            q;
    int            i;
    int            j;
    logic          found;
    logic [15:0]   hold_id;
    logic [31:0]   hold_time;
    r = NO_WANT;
    found = 1'b0;
    p = 0;
    // Scanning from the tail leaves p on the match nearest the head.
    for (j = sched_len - 1; j >= 0; j--) begin
      if (sched_ids[j] == id) begin
        found = 1'b1;
        p = j;
      end
    end
    case (cmd)
      ordq_pkg::CMD_APPEND: begin
        if (sched_len >= CAPACITY) r.status = ordq_pkg::ST_FULL;
        else sched_put_in(sched_len, id, t);
      end
      ordq_pkg::CMD_REMOVE: begin
        if (sched_len == 0) r.status = ordq_pkg::ST_EMPTY;
        else if (!found) r.status = ordq_pkg::ST_NOTFOUND;
        else sched_take_out(p);
      end
      ordq_pkg::CMD_REPOSITION: begin
        if (sched_len == 0) begin
          r.status = ordq_pkg::ST_EMPTY;
        end else if (!found) begin
          r.status = ordq_pkg::ST_NOTFOUND;
        end else if (sched_len == 1) begin
          sched_times[0] = t;
        end else begin
          hold_id = sched_ids[p];
          sched_take_out(p);
          m = sched_len;
          // After the take-out the old successor sits at p.
          if (t == ordq_pkg::TIME_INF || t >= sched_times[m - 1]) begin
            q = m;
          end else if (t <= sched_times[0] || sched_times[0] == ordq_pkg::TIME_INF) begin
            q = 0;
          end else if (p < m && sched_times[p] < t) begin
            j = p;
            while (j + 1 < m && sched_times[j] < t) j++;
            q = j;
          end else if (p > 0) begin
            j = p - 1;
            while (j > 0 && sched_times[j] > t) j--;
            q = j + 1;
          end else begin
            q = 0;
          end
          sched_put_in(q, hold_id, t);
        end
      end
      ordq_pkg::CMD_SORT: begin
        if (sched_len == 0) begin
          r.status = ordq_pkg::ST_EMPTY;
        end else begin
          for (i = 1; i < sched_len; i++) begin
            hold_id = sched_ids[i];
            hold_time = sched_times[i];
            j = i;
            while (j > 0 && sched_times[j - 1] > hold_time) begin
              sched_ids[j] = sched_ids[j - 1];
              sched_times[j] = sched_times[j - 1];
              j--;
            end
            sched_ids[j] = hold_id;
            sched_times[j] = hold_time;
          end
        end
      end
      ordq_pkg::CMD_READ: begin
        if (sched_len == 0) begin
          r.status = ordq_pkg::ST_EMPTY;
        end else if (int'(pos) >= sched_len) begin
          r.status = ordq_pkg::ST_NOTFOUND;
        end else begin
          r.rid = sched_ids[pos];
          r.rtime = sched_times[pos];
        end
      end
      ordq_pkg::CMD_CLEAR: sched_len = 0;
      default: ;
    endcase
    r.count = 7'(sched_len);
    return r;
  endfunction

  function automatic logic [15:0] pick_id();
    // A small pool of ids makes duplicates common.
    if ($urandom_range(1) == 0) return 16'($urandom_range(15));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(9))
      0: return ordq_pkg::TIME_INF;
      1: return 32'h0;
      2, 3, 4: return 32'($urandom_range(40));
      default: return $urandom;
    endcase
  endfunction

  function automatic order_cmd_t random_cmd();
    order_cmd_t c;
    int         roll;
    roll = $urandom_range(99);
    c.cmd = ordq_pkg::CMD_READ;
    c.id = pick_id();
    c.t = pick_time();
    c.pos = 6'($urandom_range(63));
    if (sched_len == CAPACITY && $urandom_range(5) == 0) growing = 1'b0;
    if (sched_len < 3) growing = 1'b1;
    if (roll < 7) begin
      // Noise: any code, including the spare ones, with random fields.
      c.cmd = 3'($urandom_range(7));
      return c;
    end
    if (roll == 7 && !growing) c.cmd = ordq_pkg::CMD_CLEAR;
    else if (roll < (growing ? 60 : 18)) c.cmd = ordq_pkg::CMD_APPEND;
    else if (roll < (growing ? 68 : 58)) c.cmd = ordq_pkg::CMD_REMOVE;
    else if (roll < 84) c.cmd = ordq_pkg::CMD_REPOSITION;
    else if (roll < 94) c.cmd = ordq_pkg::CMD_READ;
    else c.cmd = ordq_pkg::CMD_SORT;
    if (sched_len > 0) begin
      c.id = (c.cmd == ordq_pkg::CMD_APPEND) ? c.id
                                             : sched_ids[$urandom_range(sched_len - 1)];
      c.pos = 6'($urandom_range(sched_len - 1));
    end
    return c;
  endfunction

  task automatic issue(input order_cmd_t c, input logic typed, input order_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c.cmd;
    in_entry_id <= c.id;
    in_event_time <= c.t;
    in_position <= c.pos;
    cur_typed <= typed;
    cur_want <= want;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    order_result_t due;
    order_result_t head;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        due = sched_apply(in_command, in_entry_id, in_event_time, in_position);
        if (cur_typed) due = cur_want;
        if (due.status == ordq_pkg::ST_FULL) full_hits++;
        if (sched_len > peak_len) peak_len = sched_len;
        sched_results_due.push_back(due);
        cmds_seen++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (sched_results_due.size() == 0) begin
          $display("%0t: result beat with nothing outstanding: status %0d count %0d id %h time %h",
                   $time, out_status, out_entry_count, out_read_id, out_read_time);
          mismatches++;
        end else begin
          head = sched_results_due.pop_front();
          if (out_status !== head.status || out_entry_count !== head.count ||
              out_read_id !== head.rid || out_read_time !== head.rtime) begin
            $display("%0t: mismatch: expected status %0d count %0d id %h time %h",
                     $time, head.status, head.count, head.rid, head.rtime);
            $display("%0t:           got status %0d count %0d id %h time %h",
                     $time, out_status, out_entry_count, out_read_id, out_read_time);
            mismatches++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    order_cmd_t c;
    int         k;
    int         ph;
    dir_table = '{
      '{ordq_pkg::CMD_READ,       16'h0000, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_EMPTY,    7'd0, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_REMOVE,     16'h0005, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_EMPTY,    7'd0, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_REPOSITION, 16'h0005, 32'd9,    6'd0,  1'b1,
        '{ordq_pkg::ST_EMPTY,    7'd0, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_SORT,       16'h0000, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_EMPTY,    7'd0, 16'h0, 32'h0}},
      '{CMD_SPARE_A,    16'hFFFF, ordq_pkg::TIME_INF, 6'd63, 1'b1,
        '{ordq_pkg::ST_OK,       7'd0, 16'h0, 32'h0}},
      '{CMD_SPARE_B,              16'h0000, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_OK,       7'd0, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_APPEND,     16'hFFFF, ordq_pkg::TIME_INF, 6'd0, 1'b1,
        '{ordq_pkg::ST_OK,       7'd1, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_REPOSITION, 16'hFFFF, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_OK,       7'd1, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_READ,       16'h0000, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_OK,       7'd1, 16'hFFFF, 32'h0}},
      '{ordq_pkg::CMD_READ,       16'h0000, 32'h0,    6'd63, 1'b1,
        '{ordq_pkg::ST_NOTFOUND, 7'd1, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_REMOVE,     16'h0000, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_NOTFOUND, 7'd1, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_APPEND,     16'h0000, 32'd500,  6'd0,  1'b1,
        '{ordq_pkg::ST_OK,       7'd2, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_APPEND,     16'h0007, 32'd300,  6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_APPEND,     16'h0007, 32'd100,  6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_APPEND,     16'h0003, ordq_pkg::TIME_INF, 6'd0, 1'b0, NO_WANT},
      '{ordq_pkg::CMD_SORT,       16'h0000, 32'h0,    6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_REPOSITION, 16'h0007, 32'd400,  6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_REPOSITION, 16'h0000, 32'd50,   6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_REPOSITION, 16'h0003, 32'h0,    6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_REPOSITION, 16'hFFFF, ordq_pkg::TIME_INF, 6'd0, 1'b0, NO_WANT},
      '{ordq_pkg::CMD_READ,       16'h0000, 32'h0,    6'd4,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_REMOVE,     16'h0007, 32'h0,    6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_CLEAR,      16'h0000, 32'h0,    6'd0,  1'b1,
        '{ordq_pkg::ST_OK,       7'd0, 16'h0, 32'h0}},
      '{ordq_pkg::CMD_APPEND,     16'h0001, ordq_pkg::TIME_INF, 6'd0, 1'b0, NO_WANT},
      '{ordq_pkg::CMD_APPEND,     16'h0002, 32'd20,   6'd0,  1'b0, NO_WANT},
      '{ordq_pkg::CMD_REPOSITION, 16'h0002, 32'd10,   6'd0,  1'b0, NO_WANT}
    };
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < 26; k++) begin
      c.cmd = dir_table[k].cmd;
      c.id = dir_table[k].id;
      c.t = dir_table[k].t;
      c.pos = dir_table[k].pos;
      issue(c, dir_table[k].typed, dir_table[k].want);
    end

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE_PCT[ph];
      stall_pct = RECV_STALL_PCT[ph];
      for (k = 0; k < ITEMS_PER_PHASE; k++) issue(random_cmd(), 1'b0, NO_WANT);
      // Hold the next beat back until every result of this phase is in.
      in_valid <= 1'b0;
      do @(negedge clk); while (sched_results_due.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d commands (26 directed) over four sender/receiver pressure phases;",
             cmds_seen);
    $display("checked %0d results, occupancy peaked at %0d, %0d appends hit a full list.",
             results_seen, peak_len, full_hits);
    if (mismatches == 0 && sched_results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
